// ===== hdl/bse_pkg.sv =====
// Shared types for the bucket sort engine.
`default_nettype none

package bse_pkg;

    // Status of the shared bucket divider
    typedef struct packed {
        logic busy;  // iteration in progress
        logic done;  // quotient valid this cycle
    } div_stat_t;

endpackage : bse_pkg

`default_nettype wire

// ===== hdl/bucket_sort_engine_core.sv =====
// Bucket sort engine top level: load sequencer, selection scan and emit.
//
//  channel  | dir | tdata (low bit up)          | tlast
//  ---------+-----+-----------------------------+---------
//  s_axis   | in  | value                       | last_in
//  m_axis   | out | sorted_value, bucket        | last_out
//
// Loading takes one word per cycle. After the final word, each distinct value
// costs one scan of the store (one read port), a bucket division and the
// emission of its copies, one per accepted m_axis transfer.
// s_axis_tready is high only while loading; a stalled m_axis holds the word.
// Reset (aresetn low, synchronous) empties the set; the store needs no clear.
`default_nettype none

module bucket_sort_engine_core #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [VALUE_BITS-1:0] value
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [VALUE_BITS-1:0] sorted_value, then [$clog2(MAX_ITEMS)-1:0] bucket
    output logic [((VALUE_BITS+$clog2(MAX_ITEMS)+7)/8)*8-1:0] m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int IDX_BITS    = $clog2(MAX_ITEMS);
    localparam int BUCKET_BITS = $clog2(MAX_ITEMS);
    localparam int CNT_BITS    = $clog2(MAX_ITEMS + 1);
    localparam int M_TDATA_W   = ((VALUE_BITS + BUCKET_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                 state_reg,     state_next;
    logic [CNT_BITS-1:0]    count_reg,     count_next;
    logic [VALUE_BITS-1:0]  max_reg,       max_next;
    logic [CNT_BITS-1:0]    scan_cnt_reg,  scan_cnt_next;
    logic                   rd_vld_reg,    rd_vld_next;
    logic [VALUE_BITS-1:0]  best_reg,      best_next;
    logic [CNT_BITS-1:0]    best_cnt_reg,  best_cnt_next;
    logic                   found_reg,     found_next;
    logic [VALUE_BITS-1:0]  prev_reg,      prev_next;
    logic                   have_prev_reg, have_prev_next;
    logic [CNT_BITS-1:0]    emit_cnt_reg,  emit_cnt_next;
    logic                   m_valid_reg,   m_valid_next;
    logic [VALUE_BITS-1:0]  m_value_reg,   m_value_next;
    logic [BUCKET_BITS-1:0] m_bucket_reg,  m_bucket_next;
    logic                   m_last_reg,    m_last_next;

    logic                   s_accept;
    logic                   m_accept;
    logic [VALUE_BITS-1:0]  in_value;
    logic                   wr_en;
    logic                   rd_en;
    logic [VALUE_BITS-1:0]  rd_data;
    logic                   div_start;
    bse_pkg::div_stat_t     div_stat;
    logic [CNT_BITS-1:0]    quotient;
    logic [CNT_BITS-1:0]    bucket_cnt;
    logic [CNT_BITS:0]      emit_plus1;
    logic [CNT_BITS:0]      emit_plus2;
    logic                   is_cand;

    assign in_value   = s_axis_tdata[VALUE_BITS-1:0];
    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign m_accept   = m_valid_reg && m_axis_tready;
    assign wr_en      = s_accept && (count_reg < CNT_BITS'(MAX_ITEMS));
    assign rd_en      = (state_reg == ST_SCAN) && (scan_cnt_reg < count_reg);
    assign emit_plus1 = {1'b0, emit_cnt_reg} + (CNT_BITS+1)'(1);
    assign emit_plus2 = {1'b0, emit_cnt_reg} + (CNT_BITS+1)'(2);
    assign is_cand    = !have_prev_reg || (rd_data > prev_reg);

    // Clamp the quotient to count-1; a zero maximum puts everything in bucket 0
    always_comb begin
        if (max_reg == '0) begin
            bucket_cnt = '0;
        end else if (quotient >= count_reg) begin
            bucket_cnt = count_reg - CNT_BITS'(1);
        end else begin
            bucket_cnt = quotient;
        end
    end

    bse_store #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (VALUE_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_BITS-1:0]),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (scan_cnt_reg[IDX_BITS-1:0]),
        .rd_data (rd_data)
    );

    bse_div #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .value     (best_reg),
        .count     (count_reg),
        .max_value (max_reg),
        .stat      (div_stat),
        .quotient  (quotient)
    );

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        max_next       = max_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_vld_next    = rd_en;
        best_next      = best_reg;
        best_cnt_next  = best_cnt_reg;
        found_next     = found_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        emit_cnt_next  = emit_cnt_reg;
        m_valid_next   = m_valid_reg;
        m_value_next   = m_value_reg;
        m_bucket_next  = m_bucket_reg;
        m_last_next    = m_last_reg;
        div_start      = 1'b0;

        case (state_reg)
            // Store words and track the maximum; the final word starts the sort
            ST_LOAD: begin
                if (wr_en) begin
                    count_next = count_reg + CNT_BITS'(1);
                    if (in_value > max_reg) begin
                        max_next = in_value;
                    end
                end
                if (s_accept && s_axis_tlast) begin
                    state_next     = ST_SCAN;
                    scan_cnt_next  = '0;
                    found_next     = 1'b0;
                    have_prev_next = 1'b0;
                    emit_cnt_next  = '0;
                end
            end

            // Find the smallest value above the last one emitted, and its copies
            ST_SCAN: begin
                if (rd_en) begin
                    scan_cnt_next = scan_cnt_reg + CNT_BITS'(1);
                end
                if (rd_vld_reg && is_cand) begin
                    if (!found_reg || (rd_data < best_reg)) begin
                        best_next     = rd_data;
                        best_cnt_next = CNT_BITS'(1);
                        found_next    = 1'b1;
                    end else if (rd_data == best_reg) begin
                        best_cnt_next = best_cnt_reg + CNT_BITS'(1);
                    end
                end
                if (!rd_en && !rd_vld_reg) begin
                    state_next = ST_DIV;
                    div_start  = 1'b1;
                end
            end

            // Wait for the bucket index, then present the first copy
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next    = ST_EMIT;
                    m_valid_next  = 1'b1;
                    m_value_next  = best_reg;
                    m_bucket_next = bucket_cnt[BUCKET_BITS-1:0];
                    m_last_next   = (emit_plus1 == {1'b0, count_reg});
                end
            end

            // Emit every copy of the value, then rescan or finish the set
            ST_EMIT: begin
                if (m_accept) begin
                    emit_cnt_next = emit_plus1[CNT_BITS-1:0];
                    best_cnt_next = best_cnt_reg - CNT_BITS'(1);
                    if (emit_plus1 == {1'b0, count_reg}) begin
                        state_next   = ST_LOAD;
                        m_valid_next = 1'b0;
                        count_next   = '0;
                        max_next     = '0;
                    end else if (best_cnt_reg == CNT_BITS'(1)) begin
                        state_next     = ST_SCAN;
                        m_valid_next   = 1'b0;
                        prev_next      = best_reg;
                        have_prev_next = 1'b1;
                        scan_cnt_next  = '0;
                        found_next     = 1'b0;
                    end else begin
                        m_last_next = (emit_plus2 == {1'b0, count_reg});
                    end
                end
            end

            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            max_reg       <= '0;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            emit_cnt_reg  <= '0;
            best_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            have_prev_reg <= have_prev_next;
            emit_cnt_reg  <= emit_cnt_next;
            best_cnt_reg  <= best_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
        best_reg     <= best_next;
        prev_reg     <= prev_next;
        m_value_reg  <= m_value_next;
        m_bucket_reg <= m_bucket_next;
        m_last_reg   <= m_last_next;
    end

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({m_bucket_reg, m_value_reg});
    assign m_axis_tlast  = m_last_reg;

    // Loading and emitting never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a sorted word is pending");

    // The final sorted word reopens the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not reopened after final word");

    // Emitted bucket stays below the set size
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (CNT_BITS'(m_bucket_reg) < count_reg))
        else $error("bucket index out of range");

    // Each newly selected value lies strictly above the one before it
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && have_prev_reg) |-> (best_reg > prev_reg))
        else $error("sorted order broken");

endmodule : bucket_sort_engine_core

`default_nettype wire

// ===== hdl/bse_store.sv =====
// Item store: one write port, one registered read port.
`default_nettype none

module bse_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the loaded word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry a cycle; the read data is registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : bse_store

`default_nettype wire

// ===== hdl/bse_div.sv =====
// Bucket divider: floor(value*count/max), one quotient bit per cycle.
`default_nettype none

module bse_div #(
    parameter int VALUE_BITS = 16,
    parameter int CNT_BITS   = 7
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic [CNT_BITS-1:0]   count,
    input  wire logic [VALUE_BITS-1:0] max_value,
    output bse_pkg::div_stat_t         stat,
    output logic      [CNT_BITS-1:0]   quotient
);

    localparam int PW     = VALUE_BITS + CNT_BITS;
    localparam int STEP_W = $clog2(CNT_BITS + 1);

    logic [PW-1:0]       rem_reg,  rem_next;
    logic [PW-1:0]       dvs_reg,  dvs_next;
    logic [CNT_BITS-1:0] q_reg,    q_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                ge;

    // Restoring division; quotient never exceeds count, so CNT_BITS steps suffice
    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ge        = (rem_reg >= dvs_reg);
        if (start) begin
            rem_next  = PW'(value) * PW'(count);
            dvs_next  = PW'(max_value) << (CNT_BITS - 1);
            q_next    = '0;
            step_next = STEP_W'(CNT_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dvs_reg;
            end
            q_next    = {q_reg[CNT_BITS-2:0], ge};
            dvs_next  = dvs_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule : bse_div

`default_nettype wire

// ===== verif/bucket_sort_engine_core_tb.sv =====
// Self-checking testbench for the bucket sort engine: loads value sets and checks sorted output.
`timescale 1ns / 100ps

module bucket_sort_engine_core_tb;

    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_BITS  = 16;
    localparam int BUCKET_BITS = 6;
    localparam int S_BITS      = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_BITS      = ((VALUE_BITS + BUCKET_BITS + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 6000;

    typedef struct {
        logic [VALUE_BITS-1:0]  value;
        logic [BUCKET_BITS-1:0] bucket;
        logic                   last;
    } sorted_word_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_BITS-1:0]     s_axis_tdata;   // [15:0] value
    logic                  s_axis_tlast;   // last_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_BITS-1:0]     m_axis_tdata;   // [15:0] sorted_value, [21:16] bucket
    logic                  m_axis_tlast;   // last_out

    // Predictor state: the set being loaded and its running maximum
    logic [VALUE_BITS-1:0] set_values[$];
    logic [VALUE_BITS-1:0] set_max;
    sorted_word_t          expected_sorted[$];

    int mismatch_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    bucket_sort_engine_core #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint exp_v,
                                   input longint got_v);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
        mismatch_count++;
    endtask

    // Bucket every stored value, order by bucket then value, queue the results
    task automatic bucket_sort_set();
        sorted_word_t      ordered[$];
        sorted_word_t      w;
        longint unsigned   prod;
        longint unsigned   cap;
        int                n;
        int                j;
        n   = set_values.size();
        cap = n - 1;
        foreach (set_values[i]) begin
            prod = 0;
            if (set_max != 0) begin
                prod = set_values[i];
                prod = (prod * n) / set_max;
                if (prod > cap)
                    prod = cap;
            end
            w.value  = set_values[i];
            w.bucket = prod[BUCKET_BITS-1:0];
            w.last   = 1'b0;
            j = 0;
            while (j < ordered.size() && (ordered[j].bucket < w.bucket ||
                   (ordered[j].bucket == w.bucket && ordered[j].value <= w.value)))
                j++;
            ordered.insert(j, w);
        end
        ordered[n-1].last = 1'b1;
        foreach (ordered[i])
            expected_sorted.insert(expected_sorted.size(), ordered[i]);
        set_values.delete();
        set_max = '0;
    endtask

    // Fold one accepted word into the predictor
    task automatic absorb_word(input logic [VALUE_BITS-1:0] v, input logic lst);
        if (set_values.size() < MAX_ITEMS) begin
            set_values.insert(set_values.size(), v);
            if (v > set_max)
                set_max = v;
        end
        if (lst)
            bucket_sort_set();
    endtask

    // Offer one word, with a random gap first; leave valid high on return
    task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_BITS'(v);
        s_axis_tlast  <= lst;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        absorb_word(v, lst);
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        while (expected_sorted.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random value drawn in one of several styles for a set
    function automatic logic [VALUE_BITS-1:0] pick_value(input int style,
                                                         input logic [VALUE_BITS-1:0] seed_v);
        case (style)
            0: return VALUE_BITS'($urandom);
            1: return VALUE_BITS'($urandom_range(15));
            2: return ($urandom_range(1)) ? 16'hFFFF : VALUE_BITS'($urandom_range(65535, 65000));
            3: return seed_v;
            default: return VALUE_BITS'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_set(input int n);
        int                    style;
        logic [VALUE_BITS-1:0] seed_v;
        style  = $urandom_range(4);
        seed_v = ($urandom_range(2) == 0) ? '0 : VALUE_BITS'($urandom);
        for (int i = 0; i < n; i++)
            send_word(pick_value(style, seed_v), (i == n - 1));
    endtask

    // Receiver: random stalls, or a long counted hold-off when requested
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Check each sorted word against the oldest expectation
    always @(posedge aclk) begin
        sorted_word_t exp_w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_sorted.size() == 0) begin
                report_mismatch("unexpected word, pending count", 0,
                                m_axis_tdata[VALUE_BITS-1:0]);
            end else begin
                exp_w = expected_sorted.pop_front();
                if (m_axis_tdata[VALUE_BITS-1:0] !== exp_w.value)
                    report_mismatch("sorted_value", exp_w.value,
                                    m_axis_tdata[VALUE_BITS-1:0]);
                if (m_axis_tdata[VALUE_BITS+BUCKET_BITS-1:VALUE_BITS] !== exp_w.bucket)
                    report_mismatch("bucket", exp_w.bucket,
                                    m_axis_tdata[VALUE_BITS+BUCKET_BITS-1:VALUE_BITS]);
                if (m_axis_tlast !== exp_w.last)
                    report_mismatch("last_out", exp_w.last, m_axis_tlast);
            end
        end
    end

    // Extremes, single-word sets, zero maximum, duplicates at the maximum
    task automatic test_directed();
        send_word(16'h8000, 1'b1);
        send_word(16'h0000, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h7FFF, 1'b1);
        send_word(16'hAAAA, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'h0003, 1'b1);
        send_word(16'h0001, 1'b0);
        send_word(16'h0002, 1'b0);
        send_word(16'h0003, 1'b0);
        send_word(16'h0004, 1'b1);
        stop_sending();
        wait_drain();
    endtask

    // Fill the store, then offer words that must be dropped; the marker rides on one
    task automatic test_store_full();
        for (int i = 0; i < MAX_ITEMS + 3; i++)
            send_word(VALUE_BITS'($urandom), (i == MAX_ITEMS + 2));
        for (int i = 0; i < 8; i++)
            send_word(VALUE_BITS'($urandom_range(1000)), (i == 7));
        stop_sending();
        wait_drain();
    endtask

    // Random sets under one idling pattern, mostly small sizes
    task automatic test_random_sets(input int idle_pct, input int stall_pct,
                                    input int words);
        int sent;
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < words) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(MAX_ITEMS, 20)
                                         : $urandom_range(8, 1);
            send_random_set(n);
            sent += n;
        end
        stop_sending();
        wait_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Hold the receiver off while more sets are offered so the input stalls
    task automatic test_backpressure();
        hold_cycles = 3000;
        send_random_set(6);
        send_random_set(5);
        send_random_set(4);
        stop_sending();
        wait_drain();
    endtask

    initial begin
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        set_max        = '0;
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_store_full();
        test_random_sets(0, 0, 25);
        test_random_sets(86, 0, 25);
        test_random_sets(0, 86, 25);
        test_random_sets(15, 15, 25);
        test_backpressure();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_sorted.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
